>>> src/group_membership_lifecycle_core_macros.svh
// assertion macros for the group membership lifecycle core
// depends on nothing; included by the top level
`ifndef GROUP_MEMBERSHIP_LIFECYCLE_CORE_MACROS_SVH
`define GROUP_MEMBERSHIP_LIFECYCLE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define GML_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define GML_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GML_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define GML_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> src/gml_pkg.sv
// shared types and constants for the group membership lifecycle core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package gml_pkg;
  localparam int unsigned NameBytes  = 32;
  localparam int unsigned PrintWords = 4;
  localparam int unsigned PrintIdxW  = (PrintWords > 1) ? $clog2(PrintWords) : 1;
  localparam int unsigned CountW     = 6;
  localparam logic [7:0]  CharLow    = 8'h20;
  localparam logic [7:0]  CharHigh   = 8'h7E;

  localparam logic [3:0] OpProvision = 4'd0;
  localparam logic [3:0] OpRename    = 4'd1;
  localparam logic [3:0] OpJoin      = 4'd2;
  localparam logic [3:0] OpActivate  = 4'd3;
  localparam logic [3:0] OpRevoke    = 4'd4;
  localparam logic [3:0] OpLeave     = 4'd5;
  localparam logic [3:0] OpResetKeep = 4'd6;
  localparam logic [3:0] OpResetFact = 4'd7;
  localparam logic [3:0] OpCompare   = 4'd8;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StMore     = 3'd1;
  localparam logic [2:0] StBadTrans = 3'd2;
  localparam logic [2:0] StBadIdent = 3'd3;
  localparam logic [2:0] StBadName  = 3'd4;
  localparam logic [2:0] StBadGroup = 3'd5;
  localparam logic [2:0] StBadEpoch = 3'd6;
  localparam logic [2:0] StBadAlias = 3'd7;

  localparam logic [2:0] MsUnprov  = 3'd0;
  localparam logic [2:0] MsReady   = 3'd1;
  localparam logic [2:0] MsPending = 3'd2;
  localparam logic [2:0] MsActive  = 3'd3;
  localparam logic [2:0] MsRevoked = 3'd4;
  localparam logic [2:0] MsLeft    = 3'd5;

  localparam logic [1:0] VdDistinct  = 2'd0;
  localparam logic [1:0] VdSame      = 2'd1;
  localparam logic [1:0] VdCollision = 2'd2;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [63:0] group_ident;
    logic [31:0] epoch_value;
    logic [63:0] alias_value;
    logic [63:0] print_word;
    logic [7:0]  name_byte;
    logic        byte_present;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  membership_state;
    logic        can_send_group;
    logic [1:0]  alias_verdict;
    logic [63:0] group_out;
    logic [31:0] epoch_out;
    logic [63:0] alias_out;
    logic [5:0]  name_length_out;
  } result_t;
endpackage
`default_nettype wire

>>> src/group_membership_lifecycle_core.sv
// top level of the group membership lifecycle core
// depends on gml_pkg, gml_fifo, gml_back and the macros header
`timescale 1ns / 1ps
`default_nettype none
// one result per command item; front takes items into a two-entry queue,
// back applies them one per cycle into a result register, so the block
// sustains one item per cycle while the output is not stalled; the rate is
// set by the back end's single state update per cycle. fingerprints are stored as
// PrintWords words; names are checked and counted, only their length is kept.
`include "group_membership_lifecycle_core_macros.svh"
module group_membership_lifecycle_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: opcode[3:0], group_ident, epoch_value, alias_value, print_word,
  // name_byte, byte_present; zero fill to 240 bits
  input  wire logic [239:0] s_axis_tdata,
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: status, membership_state, can_send_group, alias_verdict, group_out,
  // epoch_out, alias_out, name_length_out; zero fill to 176 bits
  output logic [175:0]      m_axis_tdata
);
  import gml_pkg::*;
  item_t   in_item, q_item;
  result_t res;
  logic    q_valid, q_ready;

  // unpack the incoming transfer
  assign in_item.opcode       = s_axis_tdata[3:0];
  assign in_item.group_ident  = s_axis_tdata[67:4];
  assign in_item.epoch_value  = s_axis_tdata[99:68];
  assign in_item.alias_value  = s_axis_tdata[163:100];
  assign in_item.print_word   = s_axis_tdata[227:164];
  assign in_item.name_byte    = s_axis_tdata[235:228];
  assign in_item.byte_present = s_axis_tdata[236];
  assign in_item.last         = s_axis_tlast;

  gml_fifo u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_item_i(in_item),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_item_o(q_item)
  );

  gml_back u_back (
    .clk_i, .rst_ni,
    .in_valid_i(q_valid), .in_ready_o(q_ready), .in_item_i(q_item),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_res_o(res)
  );

  assign m_axis_tdata = {1'b0, res.name_length_out, res.alias_out, res.epoch_out,
                         res.group_out, res.alias_verdict, res.can_send_group,
                         res.membership_state, res.status};

  // active flag tracks the reported state
  `GML_ASSERT_IMP(a_send, clk_i, rst_ni, m_axis_tvalid,
    m_axis_tdata[6] == (m_axis_tdata[5:3] == MsActive), "can_send mismatch")
  // a stalled result holds
  `GML_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  // verdict only on an ok status
  `GML_ASSERT_IMP(a_vd, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[8:7] != VdDistinct,
    m_axis_tdata[2:0] == StOk, "verdict with non-ok status")
endmodule
`default_nettype wire

>>> src/gml_fifo.sv
// two-entry queue that decouples the front from the back
// depends on gml_pkg
`timescale 1ns / 1ps
`default_nettype none
module gml_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire gml_pkg::item_t in_item_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output gml_pkg::item_t     out_item_o
);
  import gml_pkg::*;
  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  assign in_ready_o  = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_item_o  = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_item_i;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

>>> src/gml_back.sv
// back end: pending command accumulation, checks, commit, result register
// depends on gml_pkg
`timescale 1ns / 1ps
`default_nettype none
module gml_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire gml_pkg::item_t in_item_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output gml_pkg::result_t    out_res_o
);
  import gml_pkg::*;
  logic [2:0]  ms_q, ms_d;
  logic [63:0] grp_q, grp_d, al_q, al_d;
  logic [31:0] ep_q, ep_d;
  logic [63:0] prn_q [PrintWords];
  logic [63:0] pprn_q [PrintWords];
  logic [CountW-1:0] nlen_q, nlen_d, cnt_q, cnt_d;
  logic [3:0]  flg_q, flg_d, kind_q, kind_d;
  logic        commit_prn;
  logic        wr_prn;
  logic        vld_q;
  result_t     res_q, res_d;
  logic        take;
  logic [PrintIdxW-1:0] pidx;
  logic [3:0]  fl;
  logic [CountW-1:0] c;
  logic [2:0]  st;
  logic [1:0]  vd;
  logic        tail_nz;
  item_t       it;

  assign it = in_item_i;
  assign in_ready_o  = !vld_q || out_ready_i;
  assign take = in_valid_i && in_ready_o;
  assign out_valid_o = vld_q;
  assign out_res_o   = res_q;
  assign pidx = cnt_q[PrintIdxW-1:0];

  always_comb begin
    ms_d = ms_q; grp_d = grp_q; al_d = al_q; ep_d = ep_q;
    nlen_d = nlen_q; cnt_d = cnt_q; flg_d = flg_q; kind_d = kind_q;
    commit_prn = 1'b0; wr_prn = 1'b0; st = StOk; vd = VdDistinct;
    fl = flg_q; c = cnt_q; tail_nz = 1'b0;
    if (it.opcode == OpProvision || it.opcode == OpRename || it.opcode == OpCompare) begin
      if (kind_q != it.opcode + 4'd1) begin
        fl = '0; c = '0;
      end
      tail_nz = 1'b0;
      for (int i = 0; i < PrintWords; i++)
        if (CountW'(i) > c && prn_q[i] != '0) tail_nz = 1'b1;
      case (it.opcode)
        OpProvision: begin
          if (it.print_word != '0) fl[0] = 1'b1;
          if (c < CountW'(PrintWords)) begin
            wr_prn = 1'b1; c = c + 1'b1;
          end else fl[2] = 1'b1;
        end
        OpRename: begin
          if (it.byte_present) begin
            if (it.name_byte < CharLow || it.name_byte > CharHigh) fl[1] = 1'b1;
            if (c < CountW'(NameBytes)) c = c + 1'b1;
            else fl[2] = 1'b1;
          end
        end
        default: begin
          if (c < CountW'(PrintWords)) begin
            if (it.print_word != prn_q[c[PrintIdxW-1:0]]) fl[3] = 1'b1;
            c = c + 1'b1;
          end else fl[3] = 1'b1;
        end
      endcase
      cnt_d = c; flg_d = fl; kind_d = it.opcode + 4'd1;
      if (!it.last) st = StMore;
      else begin
        cnt_d = '0; flg_d = '0; kind_d = '0;
        case (it.opcode)
          OpProvision: begin
            if (ms_q != MsUnprov) st = StBadTrans;
            else if (fl[2] || !fl[0]) st = StBadIdent;
            else begin commit_prn = 1'b1; ms_d = MsReady; end
          end
          OpRename: begin
            if (ms_q == MsUnprov) st = StBadTrans;
            else if (c == '0 || fl[2] || fl[1]) st = StBadName;
            else nlen_d = c;
          end
          default: begin
            if (tail_nz) fl[3] = 1'b1;
            if (al_q == '0 || it.alias_value == '0 || it.alias_value != al_q) vd = VdDistinct;
            else vd = fl[3] ? VdCollision : VdSame;
          end
        endcase
      end
    end else begin
      cnt_d = '0; flg_d = '0; kind_d = '0;
      case (it.opcode)
        OpJoin: begin
          if (ms_q != MsReady && ms_q != MsLeft) st = StBadTrans;
          else if (it.group_ident == '0) st = StBadGroup;
          else if (it.epoch_value == '0) st = StBadEpoch;
          else begin
            grp_d = it.group_ident; ep_d = it.epoch_value; al_d = '0; ms_d = MsPending;
          end
        end
        OpActivate: begin
          if (ms_q != MsPending) st = StBadTrans;
          else if (it.group_ident == '0 || it.group_ident != grp_q) st = StBadGroup;
          else if (it.epoch_value == '0 || it.epoch_value != ep_q) st = StBadEpoch;
          else if (it.alias_value == '0) st = StBadAlias;
          else begin al_d = it.alias_value; ms_d = MsActive; end
        end
        OpRevoke: begin
          if (ms_q != MsActive) st = StBadTrans;
          else if (it.group_ident == '0 || it.group_ident != grp_q) st = StBadGroup;
          else if (it.epoch_value <= ep_q) st = StBadEpoch;
          else begin ep_d = it.epoch_value; al_d = '0; ms_d = MsRevoked; end
        end
        OpLeave: begin
          if (ms_q != MsActive && ms_q != MsPending && ms_q != MsRevoked) st = StBadTrans;
          else begin grp_d = '0; al_d = '0; ep_d = '0; ms_d = MsLeft; end
        end
        OpResetKeep: begin
          if (ms_q == MsUnprov) st = StBadTrans;
          else begin
            grp_d = '0; al_d = '0; ep_d = '0; ms_d = MsReady; nlen_d = '0;
          end
        end
        OpResetFact: begin
          grp_d = '0; al_d = '0; ep_d = '0; ms_d = MsUnprov; nlen_d = '0;
        end
        default: st = StBadTrans;
      endcase
    end
    res_d.status = st;
    res_d.membership_state = ms_d;
    res_d.can_send_group = ms_d == MsActive;
    res_d.alias_verdict = vd;
    res_d.group_out = grp_d;
    res_d.epoch_out = ep_d;
    res_d.alias_out = al_d;
    res_d.name_length_out = nlen_d;
  end

  // pending words are written at this item's fill slot
  always_ff @(posedge clk_i) begin
    if (take && wr_prn)
      pprn_q[(kind_q != OpProvision + 4'd1) ? '0 : pidx] <= it.print_word;
    if (take) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q <= MsUnprov; grp_q <= '0; al_q <= '0; ep_q <= '0;
      nlen_q <= '0; cnt_q <= '0; flg_q <= '0; kind_q <= '0; vld_q <= 1'b0;
      for (int i = 0; i < PrintWords; i++) prn_q[i] <= '0;
    end else begin
      if (take) begin
        ms_q <= ms_d; grp_q <= grp_d; al_q <= al_d; ep_q <= ep_d;
        nlen_q <= nlen_d; cnt_q <= cnt_d; flg_q <= flg_d; kind_q <= kind_d;
        if (it.opcode == OpResetFact)
          for (int i = 0; i < PrintWords; i++) prn_q[i] <= '0;
        if (commit_prn)
          for (int i = 0; i < PrintWords; i++) begin
            if (CountW'(i) + 1'b1 == c) prn_q[i] <= it.print_word;
            else if (CountW'(i) < c) prn_q[i] <= pprn_q[i];
            else prn_q[i] <= '0;
          end
      end
      if (take) vld_q <= 1'b1;
      else if (out_ready_i) vld_q <= 1'b0;
    end
  end
endmodule
`default_nettype wire

>>> verif/group_membership_lifecycle_core_tb.sv
// self-checking testbench for the group membership lifecycle core
// depends on gml_pkg and group_membership_lifecycle_core; predicts each transfer in a class
`timescale 1ns / 1ps
`default_nettype none
module group_membership_lifecycle_core_tb;
  import gml_pkg::*;

  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned RandItems = 400;

  // reference state of the membership engine and queue of expected results
  class membership_scoreboard;
    logic [2:0]  mstate;
    logic [63:0] grp;
    logic [31:0] epo;
    logic [63:0] als;
    logic [63:0] prints [PrintWords];
    logic [5:0]  nlen;
    logic [63:0] pend_print [PrintWords];
    int unsigned pend_cnt;
    logic [3:0]  pend_flags;   // nonzero seen, bad char, too long, mismatch
    int          pend_kind;    // -1 when nothing pending, else the opcode
    result_t     expected_q [$];
    int          errors;

    function void clear_all();
      mstate = MsUnprov;
      grp = '0;
      epo = '0;
      als = '0;
      nlen = '0;
      for (int i = 0; i < PrintWords; i++) begin
        prints[i] = '0;
        pend_print[i] = '0;
      end
      pend_cnt = 0;
      pend_flags = '0;
      pend_kind = -1;
    endfunction

    function void drop_partial();
      pend_cnt = 0;
      pend_flags = '0;
      pend_kind = -1;
    endfunction

    function logic [2:0] run_single(item_t it);
      case (it.opcode)
        OpJoin: begin
          if (mstate != MsReady && mstate != MsLeft) return StBadTrans;
          if (it.group_ident == 0) return StBadGroup;
          if (it.epoch_value == 0) return StBadEpoch;
          grp = it.group_ident;
          epo = it.epoch_value;
          als = '0;
          mstate = MsPending;
          return StOk;
        end
        OpActivate: begin
          if (mstate != MsPending) return StBadTrans;
          if (it.group_ident == 0 || it.group_ident != grp) return StBadGroup;
          if (it.epoch_value == 0 || it.epoch_value != epo) return StBadEpoch;
          if (it.alias_value == 0) return StBadAlias;
          als = it.alias_value;
          mstate = MsActive;
          return StOk;
        end
        OpRevoke: begin
          if (mstate != MsActive) return StBadTrans;
          if (it.group_ident == 0 || it.group_ident != grp) return StBadGroup;
          if (it.epoch_value <= epo) return StBadEpoch;
          epo = it.epoch_value;
          als = '0;
          mstate = MsRevoked;
          return StOk;
        end
        OpLeave: begin
          if (mstate != MsActive && mstate != MsPending && mstate != MsRevoked)
            return StBadTrans;
          grp = '0; als = '0; epo = '0;
          mstate = MsLeft;
          return StOk;
        end
        OpResetKeep: begin
          if (mstate == MsUnprov) return StBadTrans;
          grp = '0; als = '0; epo = '0;
          mstate = MsReady;
          nlen = '0;
          return StOk;
        end
        OpResetFact: begin
          clear_all();
          return StOk;
        end
        default: return StBadTrans;
      endcase
    endfunction

    // predicts the result of one accepted input transfer
    function void note_item(item_t it);
      result_t r;
      r = '0;
      if (it.opcode == OpProvision || it.opcode == OpRename || it.opcode == OpCompare) begin
        if (pend_kind != int'(it.opcode)) begin
          drop_partial();
          pend_kind = it.opcode;
        end
        if (it.opcode == OpProvision) begin
          if (it.print_word != 0) pend_flags[0] = 1'b1;
          if (pend_cnt < PrintWords) begin
            pend_print[pend_cnt] = it.print_word;
            pend_cnt++;
          end else pend_flags[2] = 1'b1;
        end else if (it.opcode == OpRename) begin
          if (it.byte_present) begin
            if (it.name_byte < CharLow || it.name_byte > CharHigh) pend_flags[1] = 1'b1;
            if (pend_cnt < NameBytes) pend_cnt++;
            else pend_flags[2] = 1'b1;
          end
        end else begin
          if (pend_cnt < PrintWords) begin
            if (it.print_word != prints[pend_cnt]) pend_flags[3] = 1'b1;
            pend_cnt++;
          end else pend_flags[3] = 1'b1;
        end
        if (!it.last) r.status = StMore;
        else begin
          if (it.opcode == OpProvision) begin
            if (mstate != MsUnprov) r.status = StBadTrans;
            else if (pend_flags[2] || !pend_flags[0]) r.status = StBadIdent;
            else begin
              for (int i = 0; i < PrintWords; i++)
                prints[i] = (i < pend_cnt) ? pend_print[i] : '0;
              mstate = MsReady;
              r.status = StOk;
            end
          end else if (it.opcode == OpRename) begin
            if (mstate == MsUnprov) r.status = StBadTrans;
            else if (pend_cnt == 0 || pend_flags[2] || pend_flags[1]) r.status = StBadName;
            else begin
              nlen = 6'(pend_cnt);
              r.status = StOk;
            end
          end else begin
            for (int i = pend_cnt; i < PrintWords; i++)
              if (prints[i] != 0) pend_flags[3] = 1'b1;
            r.status = StOk;
            if (als == 0 || it.alias_value == 0 || it.alias_value != als)
              r.alias_verdict = VdDistinct;
            else r.alias_verdict = pend_flags[3] ? VdCollision : VdSame;
          end
          drop_partial();
        end
      end else begin
        drop_partial();
        r.status = run_single(it);
      end
      r.membership_state = mstate;
      r.can_send_group = (mstate == MsActive);
      r.group_out = grp;
      r.epoch_out = epo;
      r.alias_out = als;
      r.name_length_out = nlen;
      expected_q.push_back(r);
    endfunction

    function void report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch %s: got %0h expected %0h", what, got, want);
    endfunction

    function void check_result(result_t got);
      result_t w;
      if (expected_q.size() == 0) begin
        report("unexpected transfer", got.status, 0);
        return;
      end
      w = expected_q.pop_front();
      if (got.status != w.status) report("status", got.status, w.status);
      if (got.membership_state != w.membership_state)
        report("membership_state", got.membership_state, w.membership_state);
      if (got.can_send_group != w.can_send_group)
        report("can_send_group", got.can_send_group, w.can_send_group);
      if (got.alias_verdict != w.alias_verdict)
        report("alias_verdict", got.alias_verdict, w.alias_verdict);
      if (got.group_out != w.group_out) report("group_out", got.group_out, w.group_out);
      if (got.epoch_out != w.epoch_out) report("epoch_out", got.epoch_out, w.epoch_out);
      if (got.alias_out != w.alias_out) report("alias_out", got.alias_out, w.alias_out);
      if (got.name_length_out != w.name_length_out)
        report("name_length_out", got.name_length_out, w.name_length_out);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [239:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [175:0] m_axis_tdata;

  group_membership_lifecycle_core dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  membership_scoreboard sb = new();
  bit hold_sink = 1'b0;
  int unsigned idle_cycles = 0;
  logic [63:0] known_print [PrintWords];
  logic [63:0] last_group;
  logic [31:0] last_epoch;
  logic [63:0] last_alias;

  function automatic logic [239:0] pack_item(item_t it);
    logic [239:0] d;
    d = '0;
    d[3:0]     = it.opcode;
    d[67:4]    = it.group_ident;
    d[99:68]   = it.epoch_value;
    d[163:100] = it.alias_value;
    d[227:164] = it.print_word;
    d[235:228] = it.name_byte;
    d[236]     = it.byte_present;
    return d;
  endfunction

  function automatic result_t unpack_result(logic [175:0] d);
    result_t r;
    r.status           = d[2:0];
    r.membership_state = d[5:3];
    r.can_send_group   = d[6];
    r.alias_verdict    = d[8:7];
    r.group_out        = d[72:9];
    r.epoch_out        = d[104:73];
    r.alias_out        = d[168:105];
    r.name_length_out  = d[174:169];
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // one input transfer with a random gap in front of it; valid drops only
  // when a gap follows, so back to back transfers keep it high
  task automatic send(item_t it);
    int unsigned gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= pack_item(it);
    s_axis_tlast <= it.last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(it);
  endtask

  function automatic item_t noise_item(logic [3:0] op);
    item_t it;
    it.opcode = op;
    it.group_ident = rand64();
    it.epoch_value = $urandom();
    it.alias_value = rand64();
    it.print_word = rand64();
    it.name_byte = 8'($urandom_range(0, 255));
    it.byte_present = 1'($urandom_range(0, 1));
    it.last = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic send_op(logic [3:0] op, logic [63:0] g, logic [31:0] e, logic [63:0] a);
    item_t it;
    it = noise_item(op);
    it.group_ident = g;
    it.epoch_value = e;
    it.alias_value = a;
    send(it);
  endtask

  // fingerprint stream for provision or compare, n words
  task automatic send_print(logic [3:0] op, int n, bit reuse, logic [63:0] a);
    item_t it;
    for (int i = 0; i < n; i++) begin
      it = noise_item(op);
      it.print_word = (reuse && i < PrintWords) ? known_print[i] :
                      ($urandom_range(0, 3) == 0 ? 64'd0 : rand64());
      if (op == OpProvision && i < PrintWords) known_print[i] = it.print_word;
      it.alias_value = a;
      it.last = (i == n - 1);
      send(it);
    end
  endtask

  task automatic send_name(int n, bit clean);
    item_t it;
    for (int i = 0; i < n; i++) begin
      it = noise_item(OpRename);
      it.byte_present = (n == 1) ? 1'($urandom_range(0, 1)) : 1'b1;
      it.name_byte = (clean || $urandom_range(0, 7) != 0) ?
                     8'($urandom_range(CharLow, CharHigh)) : 8'($urandom_range(0, 255));
      it.last = (i == n - 1);
      send(it);
    end
  endtask

  // stop offering and wait for every expected result
  task automatic drain();
    if (sb.expected_q.size() != 0) begin
      s_axis_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clk_i);
    end
  endtask

  // output side: random stalls, plus the long hold-off when asked
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready)
      sb.check_result(unpack_result(m_axis_tdata));
    m_axis_tready <= !hold_sink && ($urandom_range(0, 3) == 0 || $urandom_range(0, 1) == 0);
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("[group_membership_lifecycle_core] ERROR");
      $finish;
    end
  end

  initial begin
    int pick;
    int sent;
    item_t it;
    sb.clear_all();
    sb.errors = 0;
    for (int i = 0; i < PrintWords; i++) known_print[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part: bad transitions, empty identity, full lifecycle, extremes
    send_op(OpJoin, 64'd1, 32'd1, 64'd1);
    send_op(OpResetKeep, '0, '0, '0);
    send_name(1, 1'b1);
    send_print(OpProvision, 2, 1'b1, '0);                 // all zero words: bad identity
    send_print(OpProvision, 6, 1'b0, '0);                 // too long
    it = noise_item(OpProvision); it.print_word = '1; it.last = 1'b0; send(it);
    send_op(4'd15, '1, '1, '1);                           // unknown opcode drops it
    send_print(OpProvision, PrintWords, 1'b0, '0);
    send_op(OpJoin, '0, 32'd5, '0);
    send_op(OpJoin, '1, 32'd0, '0);
    send_op(OpJoin, '1, '1 - 32'd1, '0);
    send_op(OpActivate, '1, '1 - 32'd1, '0);
    send_op(OpActivate, '1, '1 - 32'd1, '1);
    send_print(OpCompare, PrintWords, 1'b1, '1);          // same identity
    send_print(OpCompare, PrintWords + 1, 1'b1, '1);      // collision
    send_name(NameBytes + 1, 1'b1);                       // long name
    send_name(NameBytes, 1'b1);
    send_op(OpRevoke, '1, '1 - 32'd1, '0);
    send_op(OpRevoke, '1, '1, '0);
    send_op(OpLeave, '0, '0, '0);
    send_op(OpResetKeep, '0, '0, '0);
    send_op(OpResetFact, '0, '0, '0);
    drain();

    // receiver holds off while items keep coming, so the input must stall
    hold_sink = 1'b1;
    fork
      begin
        repeat (40) @(posedge clk_i);
        hold_sink = 1'b0;
      end
      for (int i = 0; i < 6; i++) send(noise_item(4'($urandom_range(0, 15))));
    join
    drain();

    // random part: mostly well-formed lifecycles with random content
    sent = 0;
    last_group = 64'd1; last_epoch = 32'd1; last_alias = 64'd1;
    while (sent < RandItems) begin
      pick = $urandom_range(0, 19);
      case (pick)
        0, 1: send_print(OpProvision, $urandom_range(1, PrintWords + 2), 1'b0, '0);
        2, 3: send_name($urandom_range(0, 3) == 0 ? $urandom_range(30, 34) :
                        $urandom_range(1, 6), $urandom_range(0, 1));
        4, 5: begin
          last_group = ($urandom_range(0, 7) == 0) ? '0 : rand64();
          last_epoch = ($urandom_range(0, 7) == 0) ? '0 : $urandom();
          send_op(OpJoin, last_group, last_epoch, '0);
        end
        6, 7: begin
          last_alias = ($urandom_range(0, 7) == 0) ? '0 : rand64();
          send_op(OpActivate, ($urandom_range(0, 7) == 0) ? rand64() : last_group,
                  ($urandom_range(0, 7) == 0) ? $urandom() : last_epoch, last_alias);
        end
        8: begin
          last_epoch = last_epoch + $urandom_range(0, 2);
          send_op(OpRevoke, ($urandom_range(0, 7) == 0) ? rand64() : last_group,
                  $urandom_range(0, 5) == 0 ? $urandom() : last_epoch, '0);
        end
        9: send_op(OpLeave, rand64(), $urandom(), rand64());
        10: send_op(OpResetKeep, rand64(), $urandom(), rand64());
        11: if ($urandom_range(0, 3) == 0) send_op(OpResetFact, '0, '0, '0);
        12, 13, 14: send_print(OpCompare, $urandom_range(1, PrintWords + 1),
                               $urandom_range(0, 3) != 0,
                               ($urandom_range(0, 3) == 0) ? rand64() : last_alias);
        15: begin
          // sender pauses until everything has come back
          drain();
          send(noise_item(4'($urandom_range(0, 15))));
        end
        default: send(noise_item(4'($urandom_range(0, 15))));
      endcase
      sent = sent + 1 + (pick < 4 || (pick >= 12 && pick <= 14) ? 2 : 0);
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("[group_membership_lifecycle_core] OK");
    end else begin
      $display("[group_membership_lifecycle_core] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
